@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for gregorian_date_add_days_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while arst_n is high.
`define GDAD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define GDAD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/gdad_pkg.sv @@
`timescale 1ns / 1ps

package gdad_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int ADD_W   = 16;
	// Wide enough for a start day plus the largest count.
	localparam int ACC_W   = 17;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd16383;
	localparam logic [ADD_W-1:0]   ADD_MAX    = 16'd65535;
	localparam logic [YEAR_W-1:0]  CYCLE_LEN  = 14'd400;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

	// Micro-operations driven into the datapath.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_WAIT  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_MOD   = 3'd2;
	localparam logic [OP_W-1:0] OP_MONTH = 3'd3;
	localparam logic [OP_W-1:0] OP_DONE  = 3'd4;

	// Jump conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_NO_ITEM  = 3'd0;
	localparam logic [COND_W-1:0] COND_YEAR_BIG = 3'd1;
	localparam logic [COND_W-1:0] COND_R_GE     = 3'd2;
	localparam logic [COND_W-1:0] COND_MORE     = 3'd3;
	localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd4;

	// Program steps.
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] S_WAIT  = 3'd0;
	localparam logic [PC_W-1:0] S_ADD   = 3'd1;
	localparam logic [PC_W-1:0] S_MOD   = 3'd2;
	localparam logic [PC_W-1:0] S_MONTH = 3'd3;
	localparam logic [PC_W-1:0] S_DONE  = 3'd4;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [ADD_W-1:0]   days_to_add;
	} gdad_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]   result_day;
		logic [MONTH_W-1:0] result_month;
		logic [YEAR_W-1:0]  result_year;
		logic               year_overflow;
	} gdad_out_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   tgt_true;
		logic [PC_W-1:0]   tgt_false;
	} ucw_t;

	// Datapath conditions seen by the sequencer.
	typedef struct packed {
		logic no_item;
		logic year_big;
		logic r_ge;
		logic more;
		logic out_busy;
	} gdad_stat_t;

	function automatic ucw_t gdad_rom(input logic [PC_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			S_WAIT:  w = '{op: OP_WAIT,  cond: COND_NO_ITEM,  tgt_true: S_WAIT,
				tgt_false: S_ADD};
			S_ADD:   w = '{op: OP_ADD,   cond: COND_YEAR_BIG, tgt_true: S_DONE,
				tgt_false: S_MOD};
			S_MOD:   w = '{op: OP_MOD,   cond: COND_R_GE,     tgt_true: S_MOD,
				tgt_false: S_MONTH};
			S_MONTH: w = '{op: OP_MONTH, cond: COND_MORE,     tgt_true: S_MONTH,
				tgt_false: S_DONE};
			S_DONE:  w = '{op: OP_DONE,  cond: COND_OUT_BUSY, tgt_true: S_DONE,
				tgt_false: S_WAIT};
			default: w = '{op: OP_WAIT,  cond: COND_NO_ITEM,  tgt_true: S_WAIT,
				tgt_false: S_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m) inside
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ hw/rtl/gdad_useq.sv @@
`timescale 1ns / 1ps

module gdad_useq import gdad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  gdad_stat_t stat,
	output logic [OP_W-1:0] op
);

	logic [PC_W-1:0] pc_q;
	ucw_t            word;
	logic            taken;

	assign word = gdad_rom(pc_q);
	assign op   = word.op;

	always_comb begin
		unique case (word.cond)
			COND_NO_ITEM:  taken = stat.no_item;
			COND_YEAR_BIG: taken = stat.year_big;
			COND_R_GE:     taken = stat.r_ge;
			COND_MORE:     taken = stat.more;
			COND_OUT_BUSY: taken = stat.out_busy;
			default:       taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= taken ? word.tgt_true : word.tgt_false;
		end
	end

endmodule

@@ hw/rtl/gregorian_date_add_days_unit.sv @@
`timescale 1ns / 1ps
// Steps per item: the wait step takes the item, the add step adds the count (or goes to the
// done step if the start year is too big), the mod step makes the K <= 40 400-year reductions
// of the start year, the month step crosses the M month ends at one month per cycle, and the
// done step registers the result. One item is in work at a time.
// The result register frees the core, which takes the next item while a result waits.
// Reset (arst_n low, asynchronous) empties the result register and returns to the wait step.
`include "assert_macros.svh"

module gregorian_date_add_days_unit import gdad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  gdad_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output gdad_out_t result
);

	logic [OP_W-1:0]    op;
	gdad_stat_t         stat;
	logic [ACC_W-1:0]   day_q;
	logic [MONTH_W-1:0] mon_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YEAR_W-1:0]  r_q;
	logic [ADD_W-1:0]   add_q;
	logic               ovf_q;
	logic               result_valid_q;
	gdad_out_t          result_q;
	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic               past_end;
	logic               at_last;

	gdad_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	assign item_stall = (op != OP_WAIT);

	// r_q holds the year modulo 400 once the reduction steps are done.
	assign leap = (r_q[1:0] == 2'd0) && (r_q != 14'd100) && (r_q != 14'd200)
		&& (r_q != 14'd300);
	assign mlen     = month_len(mon_q, leap);
	assign past_end = day_q > {{(ACC_W-DAY_W){1'b0}}, mlen};
	assign at_last  = (mon_q == MONTH_DEC) && (year_q == YEAR_MAX);

	assign stat.no_item  = !item_valid;
	assign stat.year_big = {1'b0, year_q} > {1'b0, YEAR_MAX};
	assign stat.r_ge     = r_q >= CYCLE_LEN;
	assign stat.more     = past_end && !at_last;
	assign stat.out_busy = result_valid_q && result_stall;

	always_ff @(posedge clk) begin
		case (op)
			OP_WAIT: begin
				if (item_valid) begin
					day_q  <= (item.start_day == '0) ? {{(ACC_W-1){1'b0}}, 1'b1}
						: {{(ACC_W-DAY_W){1'b0}}, item.start_day};
					mon_q  <= (item.start_month == '0) ? MONTH_JAN
						: (item.start_month > MONTH_DEC) ? MONTH_DEC : item.start_month;
					year_q <= item.start_year;
					r_q    <= item.start_year;
					add_q  <= (item.days_to_add > ADD_MAX) ? ADD_MAX : item.days_to_add;
					ovf_q  <= 1'b0;
				end
			end
			OP_ADD: begin
				day_q <= day_q + {{(ACC_W-ADD_W){1'b0}}, add_q};
				if (stat.year_big) begin
					ovf_q <= 1'b1;
				end
			end
			OP_MOD: begin
				if (stat.r_ge) begin
					r_q <= r_q - CYCLE_LEN;
				end
			end
			OP_MONTH: begin
				if (past_end) begin
					if (at_last) begin
						ovf_q <= 1'b1;
					end else begin
						day_q <= day_q - {{(ACC_W-DAY_W){1'b0}}, mlen};
						if (mon_q == MONTH_DEC) begin
							mon_q  <= MONTH_JAN;
							year_q <= year_q + 14'd1;
							r_q    <= (r_q == CYCLE_LEN - 14'd1) ? '0 : r_q + 14'd1;
						end else begin
							mon_q <= mon_q + 4'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (op == OP_DONE && !stat.out_busy) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_DONE && !stat.out_busy) begin
			if (ovf_q) begin
				result_q <= '{result_day: DAY_LAST, result_month: MONTH_DEC,
					result_year: YEAR_MAX, year_overflow: 1'b1};
			end else begin
				result_q <= '{result_day: day_q[DAY_W-1:0], result_month: mon_q,
					result_year: year_q, year_overflow: 1'b0};
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`GDAD_ASSERT(a_result_range, result_valid |-> (result.result_day != '0) && (result.result_month != '0) && (result.result_month <= MONTH_DEC), "result date out of range")
	`GDAD_ASSERT(a_ovf_saturates, (result_valid && result.year_overflow) |-> (result.result_day == DAY_LAST) && (result.result_month == MONTH_DEC) && (result.result_year == YEAR_MAX), "overflow result not saturated")
	`GDAD_ASSERT(a_cycle_reduced, (op == OP_MONTH) |-> (r_q < CYCLE_LEN) && (mon_q != '0) && (mon_q <= MONTH_DEC), "month loop entered with bad state")
	`GDAD_ASSERT(a_no_take_busy, (item_valid && !item_stall) |=> (op == OP_ADD), "item transfer did not start the add step")

endmodule

@@ tb/gregorian_date_add_days_unit_tb.sv @@
`timescale 1ns / 1ps

module gregorian_date_add_days_unit_tb;
	import gdad_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 250;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 40;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	gdad_in_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	gdad_out_t result;

	gdad_in_t  pending_dates[$];
	gdad_out_t expected_dates[$];

	int  mismatch_count = 0;
	int  results_checked = 0;
	int  cycle_count = 0;
	bit  item_taken = 1'b0;
	bit  result_taken = 1'b0;
	int  send_gap = 0;
	int  send_quiet = 0;
	int  recv_wait = 0;
	int  recv_quiet = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	gregorian_date_add_days_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_leap_year(int unsigned y);
		return (y % CYCLE_LEN == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		int unsigned len;
		case (m)
			MONTH_FEB: len = is_leap_year(y) ? 29 : 28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
			default: len = 31;
		endcase
		return len;
	endfunction

	// Walks month by month from the normalized start date, as the block does.
	function automatic gdad_out_t add_days_to_date(gdad_in_t d);
		int unsigned day;
		int unsigned mon;
		int unsigned year;
		int unsigned add;
		bit          ovf;
		gdad_out_t   r;
		day  = d.start_day;
		mon  = d.start_month;
		year = d.start_year;
		add  = d.days_to_add;
		ovf  = 1'b0;
		if (day == 0)
			day = 1;
		if (mon == 0)
			mon = MONTH_JAN;
		if (mon > MONTH_DEC)
			mon = MONTH_DEC;
		if (add > ADD_MAX)
			add = ADD_MAX;
		if (year > YEAR_MAX) begin
			ovf = 1'b1;
		end else begin
			day += add;
			while (!ovf && day > days_in_month(mon, year)) begin
				day -= days_in_month(mon, year);
				mon++;
				if (mon > MONTH_DEC) begin
					mon = MONTH_JAN;
					if (year >= YEAR_MAX)
						ovf = 1'b1;
					else
						year++;
				end
			end
		end
		if (ovf) begin
			day  = DAY_LAST;
			mon  = MONTH_DEC;
			year = YEAR_MAX;
		end
		r.result_day    = day[DAY_W-1:0];
		r.result_month  = mon[MONTH_W-1:0];
		r.result_year   = year[YEAR_W-1:0];
		r.year_overflow = ovf;
		return r;
	endfunction

	// Mostly random waits, with runs of back-to-back transfers now and then.
	function automatic int draw_gap(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			quiet_left = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic queue_date(int unsigned d, int unsigned m, int unsigned y, int unsigned a);
		gdad_in_t s;
		s.start_day   = d[DAY_W-1:0];
		s.start_month = m[MONTH_W-1:0];
		s.start_year  = y[YEAR_W-1:0];
		s.days_to_add = a[ADD_W-1:0];
		pending_dates.push_back(s);
	endtask

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// Sender: a new item goes out at the falling edge once the drawn gap has run out.
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_taken) begin
				item_valid <= 1'b1;
			end else begin
				if (item_valid)
					send_gap = draw_gap(send_quiet);
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_dates.size() != 0) begin
					item <= pending_dates.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls each result for a drawn number of cycles, or for the whole hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				recv_wait = draw_gap(recv_quiet);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
			end else if (result_valid && recv_wait > 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Once enough results have come, hold the output off long enough for the input to back up.
	always @(posedge clk) begin
		if (!hold_done && results_checked >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(posedge clk) begin
		gdad_out_t exp_date;
		item_taken   = 1'b0;
		result_taken = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				result_taken = 1'b1;
				results_checked <= results_checked + 1;
				if (expected_dates.size() == 0) begin
					$error("result transfer with no item outstanding: %0d/%0d/%0d ovf %0d",
						result.result_day, result.result_month, result.result_year,
						result.year_overflow);
					mismatch_count++;
				end else begin
					exp_date = expected_dates.pop_front();
					check_field("result_day", exp_date.result_day, result.result_day);
					check_field("result_month", exp_date.result_month, result.result_month);
					check_field("result_year", exp_date.result_year, result.result_year);
					check_field("year_overflow", exp_date.year_overflow, result.year_overflow);
				end
			end
			if (item_valid && !item_stall) begin
				item_taken = 1'b1;
				expected_dates.push_back(add_days_to_date(item));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned y;
		int unsigned a;

		// Field extremes, the clamped day and month codes, and the leap rule.
		queue_date(0, 0, 0, 0);
		queue_date(31, 15, 16383, 65535);
		queue_date(31, 2, 2023, 0);
		queue_date(31, 2, 2024, 0);
		queue_date(30, 13, 1999, 0);
		queue_date(15, 14, 1999, 1);
		queue_date(28, 2, 2000, 1);
		queue_date(28, 2, 1900, 1);
		queue_date(28, 2, 2024, 1);
		queue_date(28, 2, 2023, 1);
		queue_date(28, 2, 0, 1);
		queue_date(31, 12, 1999, 1);
		queue_date(31, 12, 16383, 0);
		queue_date(31, 12, 16383, 1);
		queue_date(1, 1, 16383, 364);
		queue_date(1, 1, 16383, 365);
		queue_date(1, 1, 0, 65535);
		queue_date(1, 1, 16200, 65535);
		queue_date(1, 1, 16210, 65535);
		queue_date(0, 4, 2100, 30);
		queue_date(30, 11, 2399, 400);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0, 1: y = 16383 - $urandom_range(0, 300);
				2, 3, 4: y = $urandom_range(1890, 2110);
				default: y = $urandom_range(0, 16383);
			endcase
			case ($urandom_range(0, 19))
				0, 1: a = $urandom_range(60000, 65535);
				2, 3: a = $urandom_range(0, 65535);
				4, 5, 6, 7, 8: a = $urandom_range(0, 5000);
				default: a = $urandom_range(0, 400);
			endcase
			queue_date($urandom_range(0, 31), $urandom_range(0, 15), y, a);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checked at the rising edge, where the sender's queue and valid are settled.
		while (pending_dates.size() != 0 || item_valid || expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_dates.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
